// ===== design/tts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  // slot modes
  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;

  // command codes
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_START_UP   = 3'd1;
  localparam logic [2:0] CMD_START_DOWN = 3'd2;
  localparam logic [2:0] CMD_STOP       = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  // per-slot update controls
  typedef struct packed {
    logic        tick;
    logic        take_up;
    logic        take_down;
    logic        stop;
    logic [31:0] dur;
  } slot_ctl_t;

  // per-slot status back to the top
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] count;
    logic        expired;
    logic        active_next;
  } slot_stat_t;

endpackage
`default_nettype wire

// ===== design/tts_slot.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tts_slot (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tts_pkg::slot_ctl_t ctl,
  output tts_pkg::slot_stat_t     stat
);
  import tts_pkg::*;

  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [31:0] count;
  logic [31:0] count_next;

  always_comb begin
    mode_next  = mode;
    count_next = count;
    if (ctl.tick) begin
      case (mode)
        MODE_DOWN: begin
          if (count == 32'd0) begin
            mode_next = MODE_FREE;
          end else begin
            count_next = count - 32'd1;
          end
        end
        MODE_UP: begin
          count_next = count + 32'd1;
        end
        default: begin
        end
      endcase
    end
    if (ctl.take_up) begin
      mode_next  = MODE_UP;
      count_next = 32'd0;
    end
    if (ctl.take_down) begin
      mode_next  = MODE_DOWN;
      count_next = ctl.dur;
    end
    if (ctl.stop) begin
      mode_next = MODE_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FREE;
    end else begin
      mode <= mode_next;
    end
  end

  // count has no reset: every start writes it
  always_ff @(posedge clk) begin
    count <= count_next;
  end

  assign stat.mode        = mode;
  assign stat.count       = count;
  assign stat.expired     = ctl.tick && (mode == MODE_DOWN) && (count == 32'd0);
  assign stat.active_next = (mode_next != MODE_FREE);

endmodule
`default_nettype wire

// ===== design/tts_alloc.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tts_alloc #(
  parameter int SLOTS = 8,
  parameter int SW    = 3
) (
  input  wire logic [SLOTS-1:0] free_vec,
  output logic                  found,
  output logic [SW-1:0]         idx
);

  // lowest free slot wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found = 1'b1;
        idx   = SW'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/tick_timer_slot_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pool of tick-driven counter slots, each free, counting down or counting up.
//
// Command channel: a beat is taken at a rising edge with start high and busy
// low. busy is high only while rst is asserted, so a command may be issued
// every cycle. command selects tick, start up-count, start down-count, stop
// or read; slot_select names the slot for stop/read, duration the down-count
// start value.
//
// Result channel: every command produces exactly one result beat, shown for
// one cycle with done high. The receiver cannot stall; a result not taken
// that cycle is gone.
//
// Throughput: one command per cycle outside reset. The command is registered,
// then one pass of decode, lowest-free priority encode and per-slot update
// (one 32-bit inc/dec per slot) lands in the slot registers and result
// register at the same edge, so the next command sees the updated pool.
//
// Reset (synchronous): all slots free, no result pending. Slot counts are
// not reset; each start writes its slot's count.
module tick_timer_slot_pool #(
  parameter int SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  slot_select,
  input  wire logic [31:0] duration,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       slot_number,
  output logic [31:0]      count_value,
  output logic [7:0]       expired_mask,
  output logic             any_active
);
  import tts_pkg::*;

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXPW = (SLOTS > 8) ? SLOTS : 8;

  // command register
  logic        v_q;
  logic [2:0]  cmd_q;
  logic [7:0]  sel_q;
  logic [31:0] dur_q;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= command;
      sel_q <= slot_select;
      dur_q <= duration;
    end
  end

  // slot row
  slot_ctl_t        ctl  [SLOTS];
  slot_stat_t       stat [SLOTS];
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] active_vec;
  logic [EXPW-1:0]  expired_all;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_slot
      tts_slot u_slot (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl[g]),
        .stat (stat[g])
      );
      assign free_vec[g]    = (stat[g].mode == MODE_FREE);
      assign active_vec[g]  = stat[g].active_next;
      assign expired_all[g] = stat[g].expired;
    end
    for (g = SLOTS; g < EXPW; g++) begin : g_pad
      assign expired_all[g] = 1'b0;
    end
  endgenerate

  logic          alloc_found;
  logic [SW-1:0] alloc_idx;

  tts_alloc #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_alloc (
    .free_vec (free_vec),
    .found    (alloc_found),
    .idx      (alloc_idx)
  );

  // decode
  logic          is_tick;
  logic          is_start;
  logic          is_down;
  logic          zero_dur;
  logic          do_start;
  logic          is_access;
  logic          sel_ok;
  logic [SW-1:0] sel_idx;
  logic          sel_up;
  logic          do_stop;
  logic [7:0]    alloc_wide;

  assign is_tick   = v_q && (cmd_q == CMD_TICK);
  assign is_down   = (cmd_q == CMD_START_DOWN);
  assign is_start  = v_q && ((cmd_q == CMD_START_UP) || is_down);
  assign zero_dur  = is_down && (dur_q == 32'd0);
  assign do_start  = is_start && !zero_dur && alloc_found;
  assign is_access = v_q && ((cmd_q == CMD_STOP) || (cmd_q == CMD_READ));
  assign sel_ok    = ({1'b0, sel_q} < 9'(SLOTS));
  assign sel_idx   = sel_q[SW-1:0];
  assign sel_up    = sel_ok && (stat[sel_idx].mode == MODE_UP);
  assign do_stop   = is_access && sel_up && (cmd_q == CMD_STOP);
  assign alloc_wide = 8'(alloc_idx);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i].tick      = is_tick;
      ctl[i].take_up   = do_start && !is_down && (alloc_idx == SW'(i));
      ctl[i].take_down = do_start && is_down && (alloc_idx == SW'(i));
      ctl[i].stop      = do_stop && (sel_idx == SW'(i));
      ctl[i].dur       = dur_q;
    end
  end

  // result values
  logic [1:0]  status_next;
  logic [2:0]  slot_next;
  logic [31:0] value_next;

  always_comb begin
    status_next = ST_OK;
    slot_next   = 3'd0;
    value_next  = 32'd0;
    if (is_start) begin
      if (zero_dur) begin
        status_next = ST_ZERO;
      end else if (!alloc_found) begin
        status_next = ST_FULL;
      end else begin
        slot_next = alloc_wide[2:0];
      end
    end else if (is_access) begin
      if (!sel_up) begin
        status_next = ST_BAD_SLOT;
      end else begin
        value_next = stat[sel_idx].count;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (v_q) begin
      status       <= status_next;
      slot_number  <= slot_next;
      count_value  <= value_next;
      expired_mask <= is_tick ? expired_all[7:0] : 8'd0;
      any_active   <= |active_vec;
    end
  end

  // every registered command yields a result beat next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    v_q |=> done)
    else $error("command without result beat");

  // result beats only ever come from a registered command
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !v_q |=> !done)
    else $error("result beat without command");

  // a full-pool result reports at least one active slot
  a_full_active: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> any_active)
    else $error("pool full reported with no active slot");

  // expirations are reported only for ticks
  a_mask_tick: assert property (@(posedge clk) disable iff (rst)
    (v_q && (cmd_q != CMD_TICK)) |=> (expired_mask == 8'd0))
    else $error("expired mask on non-tick command");

endmodule
`default_nettype wire

// ===== dv/tb_tick_timer_slot_pool.sv =====
`timescale 1ns / 1ps
// Testbench for the tick timer slot pool.
// The sender issues commands on start/busy. The block returns one result beat per
// command, marked by done, and the receiver cannot hold it off.
module tb_tick_timer_slot_pool;
  import tts_pkg::*;

  localparam int POOL_SLOTS = 8;

  // Commands 5..7 have no function and must be answered with a plain status.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam int RANDOM_BEATS   = 1825;   // plus the directed rows, about 1850
  localparam int WATCHDOG_LIMIT = 5000;   // cycles with no beat on either side
  localparam int DRAIN_LIMIT    = 64;
  localparam int TAIL_CYCLES    = 4;      // allow some margin after the drain

  // One result beat, field for field as on the ports.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_number;
    logic [31:0] count_value;
    logic [7:0]  expired_mask;
    logic        any_active;
  } timer_result_t;

  // Directed stimulus row. If has_fixed is set, the result is typed in below.
  // Otherwise it comes from the slot pool model.
  typedef struct packed {
    logic [2:0]    command;
    logic [7:0]    slot_select;
    logic [31:0]   duration;
    logic          has_fixed;
    timer_result_t fixed;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [7:0]  slot_select;
  logic [31:0] duration;
  logic        done;
  logic [1:0]  status;
  logic [2:0]  slot_number;
  logic [31:0] count_value;
  logic [7:0]  expired_mask;
  logic        any_active;

  tick_timer_slot_pool #(
    .SLOTS(POOL_SLOTS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .slot_select  (slot_select),
    .duration     (duration),
    .done         (done),
    .status       (status),
    .slot_number  (slot_number),
    .count_value  (count_value),
    .expired_mask (expired_mask),
    .any_active   (any_active)
  );

  // Clock: 2 ns period. The first rising edge is at 1 ns.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the pool. It holds a mode and a count for each slot and is
  // updated at the edge where a command is taken.
  logic [1:0]  pool_mode  [POOL_SLOTS];
  logic [31:0] pool_count [POOL_SLOTS];

  timer_result_t expected_results [$];   // results still to arrive, oldest first
  timer_result_t oldest_result;
  directed_row_t directed_rows [DIRECTED_ROWS];

  int fail_count;
  int beats_sent;
  int results_checked;
  int expiry_ticks;       // tick results that freed at least one slot
  int full_rejects;
  int counts_returned;    // stop/read beats that returned a nonzero up count
  int sender_idle_pct;
  int stall_cycles;

  // Apply one command to the pool model and return the result it should give.
  function automatic timer_result_t apply_command(input logic [2:0]  cmd,
                                                  input logic [7:0]  sel,
                                                  input logic [31:0] dur);
    timer_result_t r;
    int taken;
    r = '0;
    taken = -1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (pool_mode[i] == MODE_DOWN) begin
            if (pool_count[i] == 32'd0) begin
              // A down slot is freed on the tick after its count reaches zero.
              pool_mode[i] = MODE_FREE;
              if (i < 8) r.expired_mask[i] = 1'b1;
            end else begin
              pool_count[i] = pool_count[i] - 32'd1;
            end
          end else if (pool_mode[i] == MODE_UP) begin
            pool_count[i] = pool_count[i] + 32'd1;
          end
        end
      end
      CMD_START_UP, CMD_START_DOWN: begin
        if (cmd == CMD_START_DOWN && dur == 32'd0) begin
          // A zero duration is rejected before the pool is searched.
          r.status = ST_ZERO;
        end else begin
          // Pick the lowest free slot.
          for (int i = POOL_SLOTS - 1; i >= 0; i--)
            if (pool_mode[i] == MODE_FREE) taken = i;
          if (taken < 0) begin
            r.status = ST_FULL;
          end else begin
            pool_mode[taken]  = (cmd == CMD_START_UP) ? MODE_UP : MODE_DOWN;
            pool_count[taken] = (cmd == CMD_START_UP) ? 32'd0 : dur;
            r.slot_number     = 3'(taken);
          end
        end
      end
      CMD_STOP, CMD_READ: begin
        if (int'(sel) >= POOL_SLOTS) begin
          r.status = ST_BAD_SLOT;
        end else if (pool_mode[sel] != MODE_UP) begin
          r.status = ST_BAD_SLOT;
        end else begin
          r.count_value = pool_count[sel];
          if (cmd == CMD_STOP) pool_mode[sel] = MODE_FREE;
        end
      end
      default: ;  // spare codes: nothing changes
    endcase
    for (int i = 0; i < POOL_SLOTS; i++)
      if (pool_mode[i] != MODE_FREE) r.any_active = 1'b1;
    return r;
  endfunction

  // Send one command beat. Idle cycles come first at the current rate. The
  // beat is held until it is taken, and its result is then predicted. With a
  // fixed result the model still runs, so that it keeps pace with the block.
  task automatic send_beat(input logic [2:0]  cmd,
                           input logic [7:0]  sel,
                           input logic [31:0] dur,
                           input logic        has_fixed,
                           input timer_result_t fixed);
    timer_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      start       <= 1'b0;
      command     <= 3'($urandom);
      slot_select <= 8'($urandom);
      duration    <= $urandom;
    end
    @(negedge clk);
    start       <= 1'b1;
    command     <= cmd;
    slot_select <= sel;
    duration    <= dur;
    do @(posedge clk); while (busy);
    predicted = apply_command(cmd, sel, dur);
    expected_results.push_back(has_fixed ? fixed : predicted);
    beats_sent++;
  endtask

  // Make one random command. Most beats are well formed, so that the pool
  // fills, counts and drains. A few use out of range slots or spare codes.
  task automatic send_random_beat();
    logic [2:0]  cmd;
    logic [7:0]  sel;
    logic [31:0] dur;
    int pick;
    int offset;
    logic pool_full;
    pick = $urandom_range(0, 99);
    sel  = 8'($urandom);
    dur  = $urandom;
    pool_full = 1'b1;
    for (int i = 0; i < POOL_SLOTS; i++)
      if (pool_mode[i] == MODE_FREE) pool_full = 1'b0;
    if (pick < 35) begin
      cmd = CMD_TICK;
    end else if (pick < 50) begin
      cmd = CMD_START_UP;
    end else if (pick < 70) begin
      cmd = CMD_START_DOWN;
      // A long duration would hold its slot for the rest of the run. It is sent
      // only when the pool is full and the start will be turned away.
      if (!pool_full) begin
        if ($urandom_range(0, 19) == 0) dur = 32'd0;
        else dur = 32'($urandom_range(1, 24));
      end else if ($urandom_range(0, 9) == 0) begin
        dur = 32'd0;
      end
    end else if (pick < 95) begin
      cmd = (pick < 82) ? CMD_STOP : CMD_READ;
      if ($urandom_range(0, 9) < 7) begin
        // Prefer an up slot, searched from a random start point.
        offset = $urandom_range(0, POOL_SLOTS - 1);
        sel = 8'(offset);
        for (int k = POOL_SLOTS - 1; k >= 0; k--)
          if (pool_mode[(offset + k) % POOL_SLOTS] == MODE_UP)
            sel = 8'((offset + k) % POOL_SLOTS);
      end
    end else begin
      cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    end
    send_beat(cmd, sel, dur, 1'b0, '0);
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      fail_count++;
    end
  endtask

  // Result checker. The receiver cannot stall, so every done cycle is a beat.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("status",       32'(oldest_result.status),       32'(status));
        check_field("slot_number",  32'(oldest_result.slot_number),  32'(slot_number));
        check_field("count_value",  oldest_result.count_value,       count_value);
        check_field("expired_mask", 32'(oldest_result.expired_mask), 32'(expired_mask));
        check_field("any_active",   32'(oldest_result.any_active),   32'(any_active));
        results_checked++;
        if (oldest_result.expired_mask != 8'd0) expiry_ticks++;
        if (oldest_result.status == ST_FULL) full_rejects++;
        if (oldest_result.count_value != 32'd0) counts_returned++;
      end
    end
  end

  // Watchdog. It ends the run after too many cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tick_timer_slot_pool verification failed");
        $finish;
      end
    end
  end

  // Directed rows, with the pool state as it builds up after reset:
  //   empty pool: tick, read and stop of a free or out of range slot,
  //   a zero duration, a spare code;
  //   then an up slot is started, ticked and read;
  //   the pool is filled (down 1, down 2, up x4, down 3) and is then full
  //   for both starts, and a zero duration still takes priority;
  //   ticks run the one-tick down slot out (its mask bit shows on the second);
  //   a down slot cannot be read, slot 8 is out of range, and a stopped slot
  //   is no longer readable.
  initial begin
    directed_rows = '{
      '{CMD_TICK,       8'd0,   32'd0,          1'b1, '{ST_OK,       3'd0, 32'd0, 8'd0, 1'b0}},
      '{CMD_READ,       8'd0,   32'd0,          1'b1, '{ST_BAD_SLOT, 3'd0, 32'd0, 8'd0, 1'b0}},
      '{CMD_STOP,       8'd255, 32'hFFFF_FFFF,  1'b1, '{ST_BAD_SLOT, 3'd0, 32'd0, 8'd0, 1'b0}},
      '{CMD_START_DOWN, 8'd0,   32'd0,          1'b1, '{ST_ZERO,     3'd0, 32'd0, 8'd0, 1'b0}},
      '{CMD_SPARE_A,    8'd255, 32'hFFFF_FFFF,  1'b1, '{ST_OK,       3'd0, 32'd0, 8'd0, 1'b0}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_OK,       3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_TICK,       8'd0,   32'd0,          1'b0, '0},
      '{CMD_READ,       8'd0,   32'd0,          1'b0, '0},
      '{CMD_START_DOWN, 8'd0,   32'd1,          1'b1, '{ST_OK,       3'd1, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_DOWN, 8'd0,   32'd2,          1'b1, '{ST_OK,       3'd2, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_OK,       3'd3, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_OK,       3'd4, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_OK,       3'd5, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_OK,       3'd6, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_DOWN, 8'd0,   32'd3,          1'b1, '{ST_OK,       3'd7, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_UP,   8'd0,   32'd0,          1'b1, '{ST_FULL,     3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_DOWN, 8'd0,   32'hFFFF_FFFF,  1'b1, '{ST_FULL,     3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_START_DOWN, 8'd0,   32'd0,          1'b1, '{ST_ZERO,     3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_SPARE_B,    8'd0,   32'd0,          1'b0, '0},
      '{CMD_TICK,       8'd0,   32'd0,          1'b0, '0},
      '{CMD_TICK,       8'd0,   32'd0,          1'b0, '0},
      '{CMD_READ,       8'd2,   32'd0,          1'b1, '{ST_BAD_SLOT, 3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_STOP,       8'd8,   32'd0,          1'b1, '{ST_BAD_SLOT, 3'd0, 32'd0, 8'd0, 1'b1}},
      '{CMD_STOP,       8'd0,   32'd0,          1'b0, '0},
      '{CMD_READ,       8'd0,   32'd0,          1'b1, '{ST_BAD_SLOT, 3'd0, 32'd0, 8'd0, 1'b1}}
    };
  end

  // Main sequence.
  initial begin
    int drain_cycles;
    rst             = 1'b1;
    start           = 1'b0;
    command         = CMD_TICK;
    slot_select     = 8'd0;
    duration        = 32'd0;
    fail_count      = 0;
    beats_sent      = 0;
    results_checked = 0;
    expiry_ticks    = 0;
    full_rejects    = 0;
    counts_returned = 0;
    stall_cycles    = 0;
    sender_idle_pct = 11;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      pool_mode[i]  = MODE_FREE;
      pool_count[i] = 32'd0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_beat(directed_rows[r].command, directed_rows[r].slot_select,
                directed_rows[r].duration, directed_rows[r].has_fixed,
                directed_rows[r].fixed);

    // Three random phases: light sender gaps, heavy gaps, then back to back.
    // At the end of each phase the sender stops until the pipeline is empty.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 45 : 0;
      for (int n = 0; n < RANDOM_BEATS / 3; n++) send_random_beat();
      @(negedge clk);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end

    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d result beats never arrived", expected_results.size());
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d results.", beats_sent, results_checked);
    $display("Seen: %0d ticks that freed slots, %0d full-pool rejects, %0d up counts read.",
             expiry_ticks, full_rejects, counts_returned);
    if (fail_count == 0) begin
      $display("tick_timer_slot_pool verification clean");
    end else begin
      $display("tick_timer_slot_pool verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tts_pkg.sv
design/tts_slot.sv
design/tts_alloc.sv
design/tick_timer_slot_pool.sv
dv/tb_tick_timer_slot_pool.sv
